@@ sv/phps_pkg.sv @@
package phps_pkg;

  // End-to-end latency from accepted start to done, in cycles
  localparam int unsigned LATENCY = 108;

  // Configuration register indexes
  localparam logic [2:0] REG_LIGHT_POS = 3'd0;
  localparam logic [2:0] REG_EYE_POS   = 3'd1;
  localparam logic [2:0] REG_ATTEN     = 3'd2;
  localparam logic [2:0] REG_AMBIENT   = 3'd3;
  localparam logic [2:0] REG_INTENSITY = 3'd4;
  localparam logic [2:0] REG_MAT0      = 3'd5;
  localparam logic [2:0] REG_MAT1      = 3'd6;

  // Material word layout: ka, kd, ks (three Q0.6 each), then exponent
  localparam int unsigned KA_LSB  = 0;
  localparam int unsigned KD_LSB  = 18;
  localparam int unsigned KS_LSB  = 36;
  localparam int unsigned EXP_LSB = 54;

  typedef struct packed {
    logic [47:0] light_pos;
    logic [47:0] eye_pos;
    logic [15:0] atten;
    logic [47:0] ambient;
    logic [47:0] intensity;
    logic [58:0] mat0;
    logic [58:0] mat1;
  } cfg_t;

  // Control bits that travel with every pipeline stage
  typedef struct packed {
    logic vld;
    logic hit;
    logic mat;
  } meta_t;

  typedef struct packed {
    logic            hit;
    logic            mat;
    logic [2:0][15:0] pos;
    logic [2:0][15:0] nrm;
  } hit_t;

  // Geometry stage result: unit vectors, normal and eye distance
  typedef struct packed {
    meta_t            meta;
    logic [2:0][15:0] nrm;
    logic [2:0][15:0] l;
    logic [2:0][15:0] v;
    logic [20:0]      m_eye;
  } geom_t;

  // Specular stage result: n.l, (r.v)^e and eye distance
  typedef struct packed {
    meta_t       meta;
    logic [17:0] nl;
    logic [31:0] p;
    logic [20:0] m_eye;
  } spec_t;

  function automatic logic [58:0] mat_sel(cfg_t c, logic sel);
    return sel ? c.mat1 : c.mat0;
  endfunction

endpackage

@@ sv/phps_geom.sv @@
module phps_geom (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  phps_pkg::hit_t  hit_in,
  input  phps_pkg::cfg_t  cfg,
  output phps_pkg::geom_t geom_out
);
  import phps_pkg::*;

  localparam int unsigned SQ_STEPS = 21;
  localparam int unsigned DV_STEPS = 15;

  typedef struct packed {
    logic [23:0] rem;
    logic [20:0] root;
  } sq_state_t;

  typedef struct packed {
    logic [20:0] rem;
    logic [14:0] q;
  } dv_state_t;

  typedef struct packed {
    meta_t            meta;
    logic [2:0][15:0] nrm;
    logic [2:0][16:0] dl;
    logic [2:0][16:0] de;
  } g1_t;

  typedef struct packed {
    meta_t            meta;
    logic [2:0][15:0] nrm;
    logic [2:0][16:0] dl;
    logic [2:0][16:0] de;
    logic [2:0][31:0] ql;
    logic [2:0][31:0] qe;
  } g2_t;

  typedef struct packed {
    meta_t            meta;
    logic [2:0][15:0] nrm;
    logic [2:0][16:0] dl;
    logic [2:0][16:0] de;
    logic [41:0]      xl;
    logic [41:0]      xe;
    sq_state_t        sl;
    sq_state_t        se;
  } sq_t;

  typedef struct packed {
    meta_t                 meta;
    logic [2:0][15:0]      nrm;
    logic [2:0][16:0]      dl;
    logic [2:0][16:0]      de;
    logic [20:0]           ml;
    logic [20:0]           me;
    dv_state_t [2:0]       sl;
    dv_state_t [2:0]       se;
  } dv_t;

  // One result bit of the integer square root
  function automatic sq_state_t sqrt_step(sq_state_t s, logic [1:0] pair);
    logic [23:0] rs;
    logic [23:0] trial;
    sq_state_t   o;
    rs    = {s.rem[21:0], pair};
    trial = {1'b0, s.root, 2'b01};
    if (rs >= trial) begin
      o.rem  = rs - trial;
      o.root = {s.root[19:0], 1'b1};
    end else begin
      o.rem  = rs;
      o.root = {s.root[19:0], 1'b0};
    end
    return o;
  endfunction

  // Both roots advance by the radicand bit pair at position pos
  function automatic sq_t sq_stage(sq_t s, int unsigned pos);
    sq_t o;
    o    = s;
    o.sl = sqrt_step(s.sl, 2'(s.xl >> (2*pos)));
    o.se = sqrt_step(s.se, 2'(s.xe >> (2*pos)));
    return o;
  endfunction

  // One quotient bit of |d|*2^18 / m; dividend bits below the start are zero
  function automatic dv_state_t div_step(dv_state_t s, logic [20:0] m);
    logic [21:0] t;
    dv_state_t   o;
    t = {s.rem, 1'b0};
    if (t >= {1'b0, m}) begin
      o.rem = 21'(t - {1'b0, m});
      o.q   = {s.q[13:0], 1'b1};
    end else begin
      o.rem = t[20:0];
      o.q   = {s.q[13:0], 1'b0};
    end
    return o;
  endfunction

  // All six dividers advance by one quotient bit
  function automatic dv_t dv_stage(dv_t s);
    dv_t o;
    o = s;
    for (int i = 0; i < 3; i++) begin
      o.sl[i] = div_step(s.sl[i], s.ml);
      o.se[i] = div_step(s.se[i], s.me);
    end
    return o;
  endfunction

  function automatic logic [15:0] mag17(logic [16:0] d);
    logic [16:0] t;
    t = d[16] ? (~d + 17'd1) : d;
    return t[15:0];
  endfunction

  function automatic logic [15:0] unit_out(logic [14:0] q, logic neg, logic [20:0] m);
    logic [15:0] u;
    u = {1'b0, q};
    if (m == '0) return '0;
    return neg ? (~u + 16'd1) : u;
  endfunction

  g1_t       g1;
  g2_t       g2;
  sq_t       sq0;
  sq_t       sqp [SQ_STEPS];
  dv_t       dv0;
  dv_t       dvp [DV_STEPS];
  logic [33:0] sum_l;
  logic [33:0] sum_e;

  // Differences light - hit and eye - hit
  always_ff @(posedge clk) begin
    if (rst) begin
      g1.meta.vld <= 1'b0;
    end else begin
      g1.meta <= '{vld: in_valid, hit: hit_in.hit, mat: hit_in.mat};
      g1.nrm  <= hit_in.nrm;
      for (int i = 0; i < 3; i++) begin
        g1.dl[i] <= 17'($signed(cfg.light_pos[16*i +: 16])) - 17'($signed(hit_in.pos[i]));
        g1.de[i] <= 17'($signed(cfg.eye_pos[16*i +: 16])) - 17'($signed(hit_in.pos[i]));
      end
    end
  end

  // Squares
  always_ff @(posedge clk) begin
    if (rst) begin
      g2.meta.vld <= 1'b0;
    end else begin
      g2.meta <= g1.meta;
      g2.nrm  <= g1.nrm;
      g2.dl   <= g1.dl;
      g2.de   <= g1.de;
      for (int i = 0; i < 3; i++) begin
        g2.ql[i] <= 32'($signed(g1.dl[i]) * $signed(g1.dl[i]));
        g2.qe[i] <= 32'($signed(g1.de[i]) * $signed(g1.de[i]));
      end
    end
  end

  // Sum of squares, scaled by 2^8 so the root carries four more fraction bits
  assign sum_l = 34'(g2.ql[0]) + 34'(g2.ql[1]) + 34'(g2.ql[2]);
  assign sum_e = 34'(g2.qe[0]) + 34'(g2.qe[1]) + 34'(g2.qe[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      sq0.meta.vld <= 1'b0;
    end else begin
      sq0.meta <= g2.meta;
      sq0.nrm  <= g2.nrm;
      sq0.dl   <= g2.dl;
      sq0.de   <= g2.de;
      sq0.xl   <= {sum_l, 8'd0};
      sq0.xe   <= {sum_e, 8'd0};
      sq0.sl   <= '0;
      sq0.se   <= '0;
    end
  end

  // Square root, one result bit per stage, most significant first
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SQ_STEPS; k++) sqp[k].meta.vld <= 1'b0;
    end else begin
      sqp[0] <= sq_stage(sq0, SQ_STEPS - 1);
      for (int k = 1; k < SQ_STEPS; k++)
        sqp[k] <= sq_stage(sqp[k-1], SQ_STEPS - 1 - k);
    end
  end

  // Divider setup: remainder starts at |d|<<3, the part above the quotient bits
  always_comb begin
    dv0.meta = sqp[SQ_STEPS-1].meta;
    dv0.nrm  = sqp[SQ_STEPS-1].nrm;
    dv0.dl   = sqp[SQ_STEPS-1].dl;
    dv0.de   = sqp[SQ_STEPS-1].de;
    dv0.ml   = sqp[SQ_STEPS-1].sl.root;
    dv0.me   = sqp[SQ_STEPS-1].se.root;
    for (int i = 0; i < 3; i++) begin
      dv0.sl[i].rem = 21'({mag17(sqp[SQ_STEPS-1].dl[i]), 3'b000});
      dv0.sl[i].q   = '0;
      dv0.se[i].rem = 21'({mag17(sqp[SQ_STEPS-1].de[i]), 3'b000});
      dv0.se[i].q   = '0;
    end
  end

  // Six restoring dividers in lockstep, one quotient bit per stage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DV_STEPS; k++) dvp[k].meta.vld <= 1'b0;
    end else begin
      dvp[0] <= dv_stage(dv0);
      for (int k = 1; k < DV_STEPS; k++) dvp[k] <= dv_stage(dvp[k-1]);
    end
  end

  // Sign restore; a zero-length vector gives zero components
  always_ff @(posedge clk) begin
    if (rst) begin
      geom_out.meta.vld <= 1'b0;
    end else begin
      geom_out.meta  <= dvp[DV_STEPS-1].meta;
      geom_out.nrm   <= dvp[DV_STEPS-1].nrm;
      geom_out.m_eye <= dvp[DV_STEPS-1].me;
      for (int i = 0; i < 3; i++) begin
        geom_out.l[i] <= unit_out(dvp[DV_STEPS-1].sl[i].q, dvp[DV_STEPS-1].dl[i][16],
                                  dvp[DV_STEPS-1].ml);
        geom_out.v[i] <= unit_out(dvp[DV_STEPS-1].se[i].q, dvp[DV_STEPS-1].de[i][16],
                                  dvp[DV_STEPS-1].me);
      end
    end
  end

endmodule

@@ sv/phps_spec.sv @@
module phps_spec (
  input  logic            clk,
  input  logic            rst,
  input  phps_pkg::geom_t geom_in,
  input  phps_pkg::cfg_t  cfg,
  output phps_pkg::spec_t spec_out
);
  import phps_pkg::*;

  localparam int unsigned PW_STEPS = 31;

  typedef struct packed {
    meta_t            meta;
    logic [2:0][15:0] nrm;
    logic [2:0][15:0] l;
    logic [2:0][15:0] v;
    logic [2:0][31:0] prod;
    logic [20:0]      m_eye;
  } p1_t;

  typedef struct packed {
    meta_t            meta;
    logic [2:0][15:0] nrm;
    logic [2:0][15:0] l;
    logic [2:0][15:0] v;
    logic [17:0]      nl;
    logic [20:0]      m_eye;
  } p2_t;

  typedef struct packed {
    meta_t            meta;
    logic [2:0][15:0] l;
    logic [2:0][15:0] v;
    logic [17:0]      nl;
    logic [2:0][34:0] t;
    logic [20:0]      m_eye;
  } p3_t;

  typedef struct packed {
    meta_t            meta;
    logic [2:0][15:0] v;
    logic [17:0]      nl;
    logic [2:0][20:0] r;
    logic [20:0]      m_eye;
  } p4_t;

  typedef struct packed {
    meta_t            meta;
    logic [17:0]      nl;
    logic [2:0][36:0] pr;
    logic [20:0]      m_eye;
  } p5_t;

  typedef struct packed {
    meta_t       meta;
    logic [17:0] nl;
    logic [20:0] m_eye;
    logic [22:0] rv;
    logic [31:0] p;
  } pw_t;

  // p * rv in Q.14, floor, saturated to 32 bits
  function automatic logic [31:0] pow_step(logic [31:0] p, logic [22:0] rv);
    logic signed [54:0] prod;
    logic signed [40:0] sh;
    prod = $signed(p) * $signed(rv);
    sh   = 41'(prod >>> 14);
    if (sh[40:31] == '0 || sh[40:31] == '1) return sh[31:0];
    return sh[40] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  // Stage idx multiplies only while idx is below the item's exponent
  function automatic pw_t pow_stage(pw_t s, logic [4:0] idx, cfg_t c);
    logic [58:0] mw;
    pw_t         o;
    mw = mat_sel(c, s.meta.mat);
    o  = s;
    if (idx < mw[EXP_LSB +: 5]) o.p = pow_step(s.p, s.rv);
    return o;
  endfunction

  p1_t p1;
  p2_t p2;
  p3_t p3;
  p4_t p4;
  p5_t p5;
  pw_t pw0;
  pw_t pwp [PW_STEPS];
  logic signed [33:0] nl_sum;
  logic signed [38:0] rv_sum;

  assign nl_sum = 34'($signed(p1.prod[0])) + 34'($signed(p1.prod[1])) +
                  34'($signed(p1.prod[2]));
  assign rv_sum = 39'($signed(p5.pr[0])) + 39'($signed(p5.pr[1])) +
                  39'($signed(p5.pr[2]));

  // n.l products, sum, reflection, r.v products, sum
  always_ff @(posedge clk) begin
    if (rst) begin
      p1.meta.vld  <= 1'b0;
      p2.meta.vld  <= 1'b0;
      p3.meta.vld  <= 1'b0;
      p4.meta.vld  <= 1'b0;
      p5.meta.vld  <= 1'b0;
      pw0.meta.vld <= 1'b0;
    end else begin
      p1.meta  <= geom_in.meta;
      p1.nrm   <= geom_in.nrm;
      p1.l     <= geom_in.l;
      p1.v     <= geom_in.v;
      p1.m_eye <= geom_in.m_eye;
      for (int i = 0; i < 3; i++)
        p1.prod[i] <= 32'($signed(geom_in.nrm[i]) * $signed(geom_in.l[i]));

      p2.meta  <= p1.meta;
      p2.nrm   <= p1.nrm;
      p2.l     <= p1.l;
      p2.v     <= p1.v;
      p2.m_eye <= p1.m_eye;
      p2.nl    <= 18'(nl_sum >>> 14);

      p3.meta  <= p2.meta;
      p3.l     <= p2.l;
      p3.v     <= p2.v;
      p3.nl    <= p2.nl;
      p3.m_eye <= p2.m_eye;
      for (int i = 0; i < 3; i++)
        p3.t[i] <= {34'($signed(p2.nl) * $signed(p2.nrm[i])), 1'b0};

      p4.meta  <= p3.meta;
      p4.v     <= p3.v;
      p4.nl    <= p3.nl;
      p4.m_eye <= p3.m_eye;
      for (int i = 0; i < 3; i++)
        p4.r[i] <= 21'($signed(p3.t[i]) >>> 14) - 21'($signed(p3.l[i]));

      p5.meta  <= p4.meta;
      p5.nl    <= p4.nl;
      p5.m_eye <= p4.m_eye;
      for (int i = 0; i < 3; i++)
        p5.pr[i] <= 37'($signed(p4.r[i]) * $signed(p4.v[i]));

      pw0.meta  <= p5.meta;
      pw0.nl    <= p5.nl;
      pw0.m_eye <= p5.m_eye;
      pw0.rv    <= 23'(rv_sum >>> 14);
      pw0.p     <= 32'd16384;
    end
  end

  // Power chain: one multiply per stage, as many stages as the largest exponent
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < PW_STEPS; k++) pwp[k].meta.vld <= 1'b0;
    end else begin
      pwp[0] <= pow_stage(pw0, 5'd0, cfg);
      for (int k = 1; k < PW_STEPS; k++)
        pwp[k] <= pow_stage(pwp[k-1], 5'(k), cfg);
    end
  end

  always_comb begin
    spec_out.meta  = pwp[PW_STEPS-1].meta;
    spec_out.nl    = pwp[PW_STEPS-1].nl;
    spec_out.p     = pwp[PW_STEPS-1].p;
    spec_out.m_eye = pwp[PW_STEPS-1].m_eye;
  end

endmodule

@@ sv/phps_color.sv @@
module phps_color (
  input  logic                clk,
  input  logic                rst,
  input  phps_pkg::spec_t     spec_in,
  input  phps_pkg::cfg_t      cfg,
  output logic                done,
  output logic signed [15:0]  red,
  output logic signed [15:0]  green,
  output logic signed [15:0]  blue
);
  import phps_pkg::*;

  localparam int unsigned DV_STEPS = 26;

  typedef struct packed {
    meta_t            meta;
    logic [2:0][24:0] a;
    logic [2:0][38:0] b;
    logic [21:0]      denom;
  } c1_t;

  typedef struct packed {
    meta_t            meta;
    logic [2:0][39:0] s;
    logic [21:0]      denom;
  } c2_t;

  typedef struct packed {
    meta_t            meta;
    logic [2:0][56:0] n;
    logic [21:0]      denom;
  } c3_t;

  typedef struct packed {
    logic [21:0] rem;
    logic [25:0] lo;
    logic [25:0] q;
    logic        neg;
    logic        ovf;
  } dv_state_t;

  typedef struct packed {
    meta_t           meta;
    logic [21:0]     denom;
    logic            zero;
    dv_state_t [2:0] ch;
  } dv_t;

  // One quotient bit; low dividend bits shift in from lo
  function automatic dv_state_t lit_div_step(dv_state_t s, logic [21:0] d);
    logic [22:0] t;
    dv_state_t   o;
    o    = s;
    t    = {s.rem, s.lo[25]};
    o.lo = {s.lo[24:0], 1'b0};
    if (t >= {1'b0, d}) begin
      o.rem = 22'(t - {1'b0, d});
      o.q   = {s.q[24:0], 1'b1};
    end else begin
      o.rem = t[21:0];
      o.q   = {s.q[24:0], 1'b0};
    end
    return o;
  endfunction

  // All three channel dividers advance by one quotient bit
  function automatic dv_t lit_div_stage(dv_t s);
    dv_t o;
    o = s;
    for (int c = 0; c < 3; c++) o.ch[c] = lit_div_step(s.ch[c], s.denom);
    return o;
  endfunction

  // Ambient plus light term, to Q3.12 with saturation
  function automatic logic [15:0] shade(dv_state_t s, logic zero, logic [5:0] ka,
                                       logic [15:0] la);
    logic        [25:0] mag;
    logic        [27:0] lit;
    logic        [21:0] amb;
    logic signed [28:0] total;
    logic signed [28:0] sh;
    mag   = s.ovf ? '1 : s.q;
    lit   = zero ? '0 : (s.neg ? (~{2'b00, mag} + 28'd1) : {2'b00, mag});
    amb   = 22'(ka * la);
    total = 29'($signed(lit)) + 29'($signed({1'b0, amb}));
    sh    = total >>> 9;
    if (sh > 29'sd32767) return 16'h7FFF;
    if (sh < -29'sd32768) return 16'h8000;
    return sh[15:0];
  endfunction

  c1_t c1, c1_next;
  c2_t c2, c2_next;
  c3_t c3, c3_next;
  dv_t dv0, dv0_next;
  dv_t dvp [DV_STEPS];
  logic [58:0] mw_in;
  logic [58:0] mw_out;
  logic [2:0][15:0] rgb_next;

  // Diffuse and specular products, attenuation denominator
  always_comb begin
    mw_in         = mat_sel(cfg, spec_in.meta.mat);
    c1_next.meta  = spec_in.meta;
    c1_next.denom = 22'({cfg.atten, 4'b0000}) + 22'(spec_in.m_eye);
    for (int c = 0; c < 3; c++) begin
      c1_next.a[c] = 25'($signed({1'b0, mw_in[KD_LSB + 6*c +: 6]}) * $signed(spec_in.nl));
      c1_next.b[c] = 39'($signed({1'b0, mw_in[KS_LSB + 6*c +: 6]}) * $signed(spec_in.p));
    end
  end

  always_comb begin
    c2_next.meta  = c1.meta;
    c2_next.denom = c1.denom;
    for (int c = 0; c < 3; c++)
      c2_next.s[c] = 40'($signed(c1.a[c])) + 40'($signed(c1.b[c]));
  end

  always_comb begin
    c3_next.meta  = c2.meta;
    c3_next.denom = c2.denom;
    for (int c = 0; c < 3; c++)
      c3_next.n[c] = 57'($signed({1'b0, cfg.intensity[16*c +: 16]}) * $signed(c2.s[c]));
  end

  // Divider setup: magnitude, sign and quotient overflow past 26 bits
  always_comb begin
    logic [56:0] mag;
    logic [30:0] hi;
    dv0_next.meta  = c3.meta;
    dv0_next.denom = c3.denom;
    dv0_next.zero  = (c3.denom == '0);
    for (int c = 0; c < 3; c++) begin
      mag = c3.n[c][56] ? (~c3.n[c] + 57'd1) : c3.n[c];
      hi  = mag[56:26];
      dv0_next.ch[c].neg = c3.n[c][56];
      dv0_next.ch[c].ovf = (hi >= 31'(c3.denom));
      dv0_next.ch[c].rem = hi[21:0];
      dv0_next.ch[c].lo  = mag[25:0];
      dv0_next.ch[c].q   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1.meta.vld  <= 1'b0;
      c2.meta.vld  <= 1'b0;
      c3.meta.vld  <= 1'b0;
      dv0.meta.vld <= 1'b0;
    end else begin
      c1  <= c1_next;
      c2  <= c2_next;
      c3  <= c3_next;
      dv0 <= dv0_next;
    end
  end

  // Three restoring dividers, one quotient bit per stage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DV_STEPS; k++) dvp[k].meta.vld <= 1'b0;
    end else begin
      dvp[0] <= lit_div_stage(dv0);
      for (int k = 1; k < DV_STEPS; k++) dvp[k] <= lit_div_stage(dvp[k-1]);
    end
  end

  // Final sum and output register; a missed hit gives black
  always_comb begin
    mw_out = mat_sel(cfg, dvp[DV_STEPS-1].meta.mat);
    for (int c = 0; c < 3; c++) begin
      rgb_next[c] = dvp[DV_STEPS-1].meta.hit ?
                    shade(dvp[DV_STEPS-1].ch[c], dvp[DV_STEPS-1].zero,
                          mw_out[KA_LSB + 6*c +: 6], cfg.ambient[16*c +: 16]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= dvp[DV_STEPS-1].meta.vld;
    red   <= rgb_next[0];
    green <= rgb_next[1];
    blue  <= rgb_next[2];
  end

endmodule

@@ sv/phong_pixel_shader_core.sv @@
// Phong shader, point light: one surface hit per transaction, one color out.
// Each accepted transaction runs through the geometry, specular and color stages to done.
// Throughput: one transaction per clock; busy is high only during reset.
// The depth is set by the bit-serial square root and dividers and the
// 31-step exponent multiply chain. The receiver cannot stall the pipeline.
// Reset (rst, synchronous) clears the configuration registers and all stage valid bits.
module phong_pixel_shader_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               hit_valid,
  input  logic signed [15:0] hit_x,
  input  logic signed [15:0] hit_y,
  input  logic signed [15:0] hit_z,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic               material,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [58:0]        cfg_data,
  output logic               done,
  output logic signed [15:0] red,
  output logic signed [15:0] green,
  output logic signed [15:0] blue
);
  import phps_pkg::*;

  cfg_t  cfg;
  hit_t  hit_in;
  geom_t geom;
  spec_t spec;
  logic  accept;

  assign busy   = rst;
  assign accept = start && !busy;

  // Configuration register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LIGHT_POS: cfg.light_pos <= cfg_data[47:0];
        REG_EYE_POS:   cfg.eye_pos   <= cfg_data[47:0];
        REG_ATTEN:     cfg.atten     <= cfg_data[15:0];
        REG_AMBIENT:   cfg.ambient   <= cfg_data[47:0];
        REG_INTENSITY: cfg.intensity <= cfg_data[47:0];
        REG_MAT0:      cfg.mat0      <= cfg_data;
        REG_MAT1:      cfg.mat1      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    hit_in.hit    = hit_valid;
    hit_in.mat    = material;
    hit_in.pos[0] = hit_x;
    hit_in.pos[1] = hit_y;
    hit_in.pos[2] = hit_z;
    hit_in.nrm[0] = normal_x;
    hit_in.nrm[1] = normal_y;
    hit_in.nrm[2] = normal_z;
  end

  phps_geom u_geom (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .hit_in   (hit_in),
    .cfg      (cfg),
    .geom_out (geom)
  );

  phps_spec u_spec (
    .clk      (clk),
    .rst      (rst),
    .geom_in  (geom),
    .cfg      (cfg),
    .spec_out (spec)
  );

  phps_color u_color (
    .clk     (clk),
    .rst     (rst),
    .spec_in (spec),
    .cfg     (cfg),
    .done    (done),
    .red     (red),
    .green   (green),
    .blue    (blue)
  );

endmodule

@@ sv/phps_checker.sv @@
module phps_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               hit_valid,
  input logic signed [15:0] hit_x,
  input logic signed [15:0] hit_y,
  input logic signed [15:0] hit_z,
  input logic signed [15:0] normal_x,
  input logic signed [15:0] normal_y,
  input logic signed [15:0] normal_z,
  input logic               material,
  input logic               cfg_we,
  input logic [2:0]         cfg_index,
  input logic [58:0]        cfg_data,
  input logic               done,
  input logic signed [15:0] red,
  input logic signed [15:0] green,
  input logic signed [15:0] blue
);
  import phps_pkg::*;

  logic [LATENCY-1:0] acc_line;
  logic [LATENCY-1:0] hv_line;

  // Port-side model of the fixed pipeline delay
  always_ff @(posedge clk) begin
    hv_line <= {hv_line[LATENCY-2:0], hit_valid};
    if (rst) acc_line <= '0;
    else     acc_line <= {acc_line[LATENCY-2:0], start && !busy};
  end

  // Every accepted transaction returns exactly once, after the fixed latency
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done == acc_line[LATENCY-1])
    else $error("done does not match accepted transaction delayed by latency");

  // A miss comes back black
  a_miss_black: assert property (@(posedge clk) disable iff (rst)
    done && !hv_line[LATENCY-1] |-> red == 16'sd0 && green == 16'sd0 && blue == 16'sd0)
    else $error("missed hit produced a nonzero color");

  // Nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) $past(rst) |-> !done)
    else $error("done asserted right after reset");

  // No transaction is taken during reset
  a_busy_reset: assert property (@(posedge clk) rst |-> busy)
    else $error("not busy during reset");

endmodule

bind phong_pixel_shader_core phps_checker u_phps_checker (.*);
